// ----- rtl/xsp_pkg.sv -----
// Shared constants and types for the xoshiro256++ generator with splitmix seeding.
`default_nettype none
package xsp_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned BOUND_W = 31;
  localparam int unsigned CNT_W = 6;

  localparam logic [WORD_W-1:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_A = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_B = 64'h94d049bb133111eb;

  localparam int unsigned SH_MIX0 = 30;
  localparam int unsigned SH_MIX1 = 27;
  localparam int unsigned SH_MIX2 = 31;
  localparam int unsigned SH_T = 17;
  localparam int unsigned ROT_OUT = 23;
  localparam int unsigned ROT_S3 = 45;

  localparam logic [1:0] MODE_RESEED = 2'd0;
  localparam logic [1:0] MODE_RAW = 2'd1;
  localparam logic [1:0] MODE_BOUNDED = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_STEP,
    ST_MOD_WAIT,
    ST_MIX_ADD,
    ST_MUL_A,
    ST_MUL_B,
    ST_FIN
  } state_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/xsp_cmul.sv -----
// Bit-serial multiplier: 64-bit operand times a 64-bit multiplier input, low 64 bits.
`default_nettype none
module xsp_cmul (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [xsp_pkg::WORD_W-1:0]  mcand,
  input  wire logic [xsp_pkg::WORD_W-1:0]  mult,
  output logic                             done,
  output logic [xsp_pkg::WORD_W-1:0]       prod
);

  logic [xsp_pkg::WORD_W-1:0] mcand_r, mcand_nxt;
  logic [xsp_pkg::WORD_W-1:0] k_r, k_nxt;
  logic [xsp_pkg::WORD_W-1:0] acc_r, acc_nxt;
  logic [xsp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       run_r, run_nxt;
  logic                       done_r, done_nxt;

  always_comb begin
    mcand_nxt = mcand_r;
    k_nxt = k_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    done_nxt = 1'b0;
    if (start) begin
      mcand_nxt = mcand;
      k_nxt = mult;
      acc_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (k_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = mcand_r << 1;
      k_nxt = k_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    k_r <= k_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

// ----- rtl/xsp_mod.sv -----
// Bit-serial restoring remainder of a 64-bit value by a 31-bit bound.
`default_nettype none
module xsp_mod (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [xsp_pkg::WORD_W-1:0]  dividend,
  input  wire logic [xsp_pkg::BOUND_W-1:0] bound,
  output logic                             done,
  output logic [xsp_pkg::BOUND_W-1:0]      rem
);

  logic [xsp_pkg::WORD_W-1:0]  q_r, q_nxt;
  logic [xsp_pkg::BOUND_W-1:0] bound_r, bound_nxt;
  logic [xsp_pkg::BOUND_W-1:0] rem_r, rem_nxt;
  logic [xsp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [xsp_pkg::BOUND_W:0]   trial;
  logic [xsp_pkg::BOUND_W:0]   diff;

  always_comb begin
    q_nxt = q_r;
    bound_nxt = bound_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    done_nxt = 1'b0;
    trial = {rem_r, q_r[xsp_pkg::WORD_W-1]};
    diff = trial - {1'b0, bound_r};
    if (start) begin
      q_nxt = dividend;
      bound_nxt = bound;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, bound_r}) begin
        rem_nxt = diff[xsp_pkg::BOUND_W-1:0];
      end else begin
        rem_nxt = trial[xsp_pkg::BOUND_W-1:0];
      end
      q_nxt = q_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    bound_r <= bound_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign rem = rem_r;

endmodule
`default_nettype wire

// ----- rtl/xoshiro256pp_prng_with_splitmix_seed.sv -----
// Raw draws pass through ST_SUM, ST_STEP and ST_FIN; bounded draws add the
// bit-serial remainder; reseed runs eight bit-serial multiplies; a bad bound or an
// unused mode goes straight to ST_FIN. One item at a time: in_ready returns with
// out_valid once the result is registered, which waits in ST_FIN while an earlier result is not yet accepted.
// Reset (synchronous, rst_n low) clears seed and runs the seed-zero expansion;
// in_ready first rises once that expansion has finished.
`default_nettype none
module xoshiro256pp_prng_with_splitmix_seed (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_mode,
  input  wire logic [xsp_pkg::BOUND_W-1:0] in_bound,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [xsp_pkg::WORD_W-1:0]       out_value,
  output logic                             out_bad_bound,
  input  wire logic                        cfg_we,
  input  wire logic [xsp_pkg::WORD_W-1:0]  cfg_wdata
);

  localparam int unsigned W = xsp_pkg::WORD_W;

  xsp_pkg::state_t state_r, state_nxt;

  logic [W-1:0] s_r [0:3];
  logic [W-1:0] s_nxt [0:3];
  logic [W-1:0] seed_r, seed_nxt;
  logic [W-1:0] w_r, w_nxt;
  logic [W-1:0] sum_r, sum_nxt;
  logic [W-1:0] res_r, res_nxt;
  logic         bad_r, bad_nxt;
  logic         is_mod_r, is_mod_nxt;
  logic         emit_r, emit_nxt;
  logic [1:0]   idx_r, idx_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_value_r, out_value_nxt;
  logic         out_bad_r, out_bad_nxt;

  logic                        mul_start;
  logic [W-1:0]                mul_mcand;
  logic [W-1:0]                mul_mult;
  logic                        mul_done;
  logic [W-1:0]                mul_prod;
  logic                        mod_start;
  logic                        mod_done;
  logic [xsp_pkg::BOUND_W-1:0] mod_rem;
  logic [W-1:0]                step_res;
  logic [W-1:0]                t_add;
  logic [W-1:0]                z_fin;
  logic [W-1:0]                n0, n1, n2, n3, tsh;

  xsp_cmul u_cmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mcand (mul_mcand),
    .mult  (mul_mult),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  xsp_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (step_res),
    .bound    (res_r[xsp_pkg::BOUND_W-1:0]),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    step_res = xsp_pkg::rotl(sum_r, xsp_pkg::ROT_OUT) + s_r[0];
    tsh = s_r[1] << xsp_pkg::SH_T;
    n2 = s_r[2] ^ s_r[0];
    n3 = s_r[3] ^ s_r[1];
    n1 = s_r[1] ^ n2;
    n0 = s_r[0] ^ n3;
    t_add = w_r + xsp_pkg::GOLDEN;
    z_fin = mul_prod ^ (mul_prod >> xsp_pkg::SH_MIX2);
  end

  always_comb begin
    state_nxt = state_r;
    for (int i = 0; i < 4; i++) begin
      s_nxt[i] = s_r[i];
    end
    seed_nxt = cfg_we ? cfg_wdata : seed_r;
    w_nxt = w_r;
    sum_nxt = sum_r;
    res_nxt = res_r;
    bad_nxt = bad_r;
    is_mod_nxt = is_mod_r;
    emit_nxt = emit_r;
    idx_nxt = idx_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_value_nxt = out_value_r;
    out_bad_nxt = out_bad_r;
    in_ready = 1'b0;
    mul_start = 1'b0;
    mul_mcand = '0;
    mul_mult = xsp_pkg::MIX_A;
    mod_start = 1'b0;

    case (state_r)
      xsp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_nxt = '0;
          bad_nxt = 1'b0;
          emit_nxt = 1'b1;
          case (in_mode)
            xsp_pkg::MODE_RESEED: begin
              w_nxt = seed_r;
              idx_nxt = '0;
              state_nxt = xsp_pkg::ST_MIX_ADD;
            end
            xsp_pkg::MODE_RAW: begin
              is_mod_nxt = 1'b0;
              state_nxt = xsp_pkg::ST_SUM;
            end
            xsp_pkg::MODE_BOUNDED: begin
              if (in_bound == '0) begin
                bad_nxt = 1'b1;
                state_nxt = xsp_pkg::ST_FIN;
              end else begin
                res_nxt = {{(W - xsp_pkg::BOUND_W){1'b0}}, in_bound};
                is_mod_nxt = 1'b1;
                state_nxt = xsp_pkg::ST_SUM;
              end
            end
            default: begin
              state_nxt = xsp_pkg::ST_FIN;
            end
          endcase
        end
      end
      xsp_pkg::ST_SUM: begin
        sum_nxt = s_r[0] + s_r[3];
        state_nxt = xsp_pkg::ST_STEP;
      end
      xsp_pkg::ST_STEP: begin
        s_nxt[0] = n0;
        s_nxt[1] = n1;
        s_nxt[2] = n2 ^ tsh;
        s_nxt[3] = xsp_pkg::rotl(n3, xsp_pkg::ROT_S3);
        if (is_mod_r) begin
          mod_start = 1'b1;
          state_nxt = xsp_pkg::ST_MOD_WAIT;
        end else begin
          res_nxt = step_res;
          state_nxt = xsp_pkg::ST_FIN;
        end
      end
      xsp_pkg::ST_MOD_WAIT: begin
        if (mod_done) begin
          res_nxt = {{(W - xsp_pkg::BOUND_W){1'b0}}, mod_rem} + {{(W - 1){1'b0}}, 1'b1};
          state_nxt = xsp_pkg::ST_FIN;
        end
      end
      xsp_pkg::ST_MIX_ADD: begin
        mul_start = 1'b1;
        mul_mcand = t_add ^ (t_add >> xsp_pkg::SH_MIX0);
        mul_mult = xsp_pkg::MIX_A;
        state_nxt = xsp_pkg::ST_MUL_A;
      end
      xsp_pkg::ST_MUL_A: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_mcand = mul_prod ^ (mul_prod >> xsp_pkg::SH_MIX1);
          mul_mult = xsp_pkg::MIX_B;
          state_nxt = xsp_pkg::ST_MUL_B;
        end
      end
      xsp_pkg::ST_MUL_B: begin
        if (mul_done) begin
          s_nxt[idx_r] = z_fin;
          w_nxt = z_fin;
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 2'd3) begin
            state_nxt = emit_r ? xsp_pkg::ST_FIN : xsp_pkg::ST_IDLE;
          end else begin
            state_nxt = xsp_pkg::ST_MIX_ADD;
          end
        end
      end
      xsp_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          out_bad_nxt = bad_r;
          state_nxt = xsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = xsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s_r[i] <= s_nxt[i];
    end
    sum_r <= sum_nxt;
    res_r <= res_nxt;
    bad_r <= bad_nxt;
    is_mod_r <= is_mod_nxt;
    out_value_r <= out_value_nxt;
    out_bad_r <= out_bad_nxt;
    if (!rst_n) begin
      state_r <= xsp_pkg::ST_MIX_ADD;
      seed_r <= '0;
      w_r <= '0;
      idx_r <= '0;
      emit_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seed_r <= seed_nxt;
      w_r <= w_nxt;
      idx_r <= idx_nxt;
      emit_r <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_bad_bound = out_bad_r;

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the xoshiro256++ generator with chained splitmix seeding.
module testbench;

  localparam int unsigned CLK_HALF = 6;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned SEGMENTS = 6;
  localparam int unsigned SEGMENT_ITEMS = 184;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [xsp_pkg::BOUND_W-1:0] BOUND_MAX = '1;
  localparam logic [xsp_pkg::WORD_W-1:0] SEED_ONES = '1;

  typedef struct packed {
    logic [1:0]                  mode;
    logic [xsp_pkg::BOUND_W-1:0] bound;
  } draw_req_t;

  typedef struct packed {
    logic [xsp_pkg::WORD_W-1:0] value;
    logic                       bad_bound;
  } draw_res_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  in_mode = '0;
  logic [xsp_pkg::BOUND_W-1:0] in_bound = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [xsp_pkg::WORD_W-1:0]  out_value;
  logic                        out_bad_bound;
  logic                        cfg_we = 1'b0;
  logic [xsp_pkg::WORD_W-1:0]  cfg_wdata = '0;

  draw_req_t                  pending_reqs[$];
  draw_res_t                  expected_draws[$];
  logic [xsp_pkg::WORD_W-1:0] model_seed;
  logic [xsp_pkg::WORD_W-1:0] model_words [4];

  int unsigned src_idle_pct = 31;
  int unsigned snk_idle_pct = 69;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  xoshiro256pp_prng_with_splitmix_seed u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_bound     (in_bound),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_bad_bound(out_bad_bound),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [63:0] rotate_left(input logic [63:0] v, input int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

  function automatic logic [63:0] splitmix_step(input logic [63:0] v);
    logic [63:0] z;
    z = v + xsp_pkg::GOLDEN;
    z = (z ^ (z >> xsp_pkg::SH_MIX0)) * xsp_pkg::MIX_A;
    z = (z ^ (z >> xsp_pkg::SH_MIX1)) * xsp_pkg::MIX_B;
    return z ^ (z >> xsp_pkg::SH_MIX2);
  endfunction

  function automatic void expand_seed_words(input logic [63:0] s);
    logic [63:0] w;
    int          i;
    w = s;
    for (i = 0; i < 4; i++) begin
      w = splitmix_step(w);
      model_words[i] = w;
    end
  endfunction

  function automatic logic [63:0] next_xoshiro_output();
    logic [63:0] res;
    logic [63:0] t;
    res = rotate_left(model_words[0] + model_words[3], xsp_pkg::ROT_OUT) + model_words[0];
    t = model_words[1] << xsp_pkg::SH_T;
    model_words[2] = model_words[2] ^ model_words[0];
    model_words[3] = model_words[3] ^ model_words[1];
    model_words[1] = model_words[1] ^ model_words[2];
    model_words[0] = model_words[0] ^ model_words[3];
    model_words[2] = model_words[2] ^ t;
    model_words[3] = rotate_left(model_words[3], xsp_pkg::ROT_S3);
    return res;
  endfunction

  function automatic draw_res_t predict_draw(input draw_req_t req);
    draw_res_t r;
    r.value = '0;
    r.bad_bound = 1'b0;
    case (req.mode)
      xsp_pkg::MODE_RESEED: expand_seed_words(model_seed);
      xsp_pkg::MODE_RAW: r.value = next_xoshiro_output();
      xsp_pkg::MODE_BOUNDED: begin
        if (req.bound == '0) r.bad_bound = 1'b1;
        else r.value = (next_xoshiro_output() % {33'd0, req.bound}) + 64'd1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic draw_req_t random_draw_req();
    draw_req_t   req;
    int unsigned pick;
    logic [31:0] r32;
    pick = $urandom_range(0, 99);
    r32 = $urandom();
    req.bound = r32[xsp_pkg::BOUND_W-1:0];
    if (pick < 4) begin
      req.mode = xsp_pkg::MODE_RESEED;
    end else if (pick < 7) begin
      req.mode = MODE_UNUSED;
    end else if (pick < 10) begin
      req.mode = xsp_pkg::MODE_BOUNDED;
      req.bound = '0;
    end else if (pick < 50) begin
      req.mode = xsp_pkg::MODE_RAW;
    end else begin
      req.mode = xsp_pkg::MODE_BOUNDED;
      case ($urandom_range(0, 3))
        0: begin
          r32 = $urandom_range(1, 16);
          req.bound = r32[xsp_pkg::BOUND_W-1:0];
        end
        1: begin
          r32 = $urandom_range(0, 3);
          req.bound = BOUND_MAX - r32[xsp_pkg::BOUND_W-1:0];
        end
        2: req.bound = 31'd1 << $urandom_range(0, 30);
        default: ;
      endcase
    end
    return req;
  endfunction

  task automatic queue_req(input logic [1:0] mode, input logic [xsp_pkg::BOUND_W-1:0] bound);
    draw_req_t req;
    req.mode = mode;
    req.bound = bound;
    pending_reqs.push_back(req);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_draws.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [xsp_pkg::WORD_W-1:0] s);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    model_seed = s;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus sequencing and seed register writes
  initial begin
    int unsigned seg;
    int unsigned n;
    model_seed = '0;
    expand_seed_words('0);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset seed: draws, bound extremes, bad bound, unused mode, literal zero reseed
    queue_req(xsp_pkg::MODE_RAW, '0);
    queue_req(xsp_pkg::MODE_BOUNDED, 31'd1);
    queue_req(xsp_pkg::MODE_BOUNDED, BOUND_MAX);
    queue_req(xsp_pkg::MODE_BOUNDED, '0);
    queue_req(MODE_UNUSED, BOUND_MAX);
    queue_req(xsp_pkg::MODE_RAW, BOUND_MAX);
    queue_req(xsp_pkg::MODE_BOUNDED, 31'h5555_5555);
    queue_req(xsp_pkg::MODE_BOUNDED, 31'h2aaa_aaaa);
    queue_req(MODE_UNUSED, '0);
    queue_req(xsp_pkg::MODE_RESEED, BOUND_MAX);
    queue_req(xsp_pkg::MODE_RAW, '0);
    queue_req(xsp_pkg::MODE_BOUNDED, 31'd2);
    wait_drained();

    // seed written without reseed must not change the state
    write_seed(SEED_ONES);
    queue_req(xsp_pkg::MODE_RAW, '0);
    queue_req(xsp_pkg::MODE_RESEED, '0);
    queue_req(xsp_pkg::MODE_RAW, '0);
    queue_req(xsp_pkg::MODE_BOUNDED, 31'h4000_0000);
    queue_req(xsp_pkg::MODE_BOUNDED, 31'd3);
    wait_drained();

    write_seed(64'h8000_0000_0000_0001);
    queue_req(xsp_pkg::MODE_RESEED, '0);
    queue_req(xsp_pkg::MODE_RAW, '0);
    queue_req(xsp_pkg::MODE_BOUNDED, BOUND_MAX);
    wait_drained();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          src_idle_pct = 31;
          snk_idle_pct = 69;
        end
        1: begin
          src_idle_pct = 69;
          snk_idle_pct = 31;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      case (seg)
        1: write_seed('0);
        3: write_seed(SEED_ONES);
        default: write_seed({$urandom(), $urandom()});
      endcase
      queue_req(xsp_pkg::MODE_RESEED, '0);
      for (n = 1; n < SEGMENT_ITEMS; n++)
        pending_reqs.push_back(random_draw_req());
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_draws.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // driver: offers queued requests, predicts each transfer
  always @(posedge clk) begin
    draw_req_t seen;
    draw_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        seen.mode = in_mode;
        seen.bound = in_bound;
        expected_draws.push_back(predict_draw(seen));
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          req = pending_reqs.pop_front();
          in_mode <= req.mode;
          in_bound <= req.bound;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results, drives out_ready with random and long stalls
  always @(posedge clk) begin
    draw_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen = results_seen + 1;
        if (results_seen % 400 == 200) hold_left = HOLD_OFF_CYCLES;
        if (expected_draws.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result %0d: value %h bad_bound %b",
                     results_seen, out_value, out_bad_bound);
        end else begin
          want = expected_draws.pop_front();
          if (out_value !== want.value || out_bad_bound !== want.bad_bound) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch on result %0d: value exp %h got %h, bad_bound exp %b got %b",
                       results_seen, want.value, out_value, want.bad_bound, out_bad_bound);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// ----- files.f -----
rtl/xsp_pkg.sv
rtl/xsp_cmul.sv
rtl/xsp_mod.sv
rtl/xoshiro256pp_prng_with_splitmix_seed.sv
sim/testbench.sv
